// ===== design/lpdc_pkg.sv =====
`default_nettype none
package lpdc_pkg;

  localparam int NumVars    = 7;
  localparam int TableBits  = 128;
  localparam int NumPairs   = 15;
  localparam int NumTriples = 35;

  localparam logic [2:0] KIND_SMALL       = 3'd0;
  localparam logic [2:0] KIND_MUX         = 3'd1;
  localparam logic [2:0] KIND_DISJOINT    = 3'd2;
  localparam logic [2:0] KIND_NONDISJOINT = 3'd3;
  localparam logic [2:0] KIND_NONE        = 3'd4;

  // load strobes for the two inner pipeline stages
  typedef struct packed {
    logic ld1;
    logic ld2;
  } stage_ld_t;

  // bit m set where minterm m has variable k high
  function automatic logic [NumVars-1:0][TableBits-1:0] gen_var_masks();
    logic [NumVars-1:0][TableBits-1:0] res;
    for (int k = 0; k < NumVars; k++) begin
      for (int m = 0; m < TableBits; m++) begin
        res[k][m] = ((m >> k) & 1) != 0;
      end
    end
    return res;
  endfunction

  localparam logic [NumVars-1:0][TableBits-1:0] VarMask = gen_var_masks();

  // variable set of the idx-th pair over six variables
  function automatic logic [NumVars-1:0] pair_sel(input int idx);
    logic [NumVars-1:0] res;
    int cnt;
    res = '0;
    cnt = 0;
    for (int v = 0; v < 6; v++) begin
      for (int u = v + 1; u < 6; u++) begin
        if (cnt == idx) begin
          res = NumVars'((1 << v) | (1 << u));
        end
        cnt++;
      end
    end
    return res;
  endfunction

  // variable set of the idx-th triple over seven variables
  function automatic logic [NumVars-1:0] triple_sel(input int idx);
    logic [NumVars-1:0] res;
    int cnt;
    res = '0;
    cnt = 0;
    for (int v = 0; v < 7; v++) begin
      for (int u = v + 1; u < 7; u++) begin
        for (int y = u + 1; y < 7; y++) begin
          if (cnt == idx) begin
            res = NumVars'((1 << v) | (1 << u) | (1 << y));
          end
          cnt++;
        end
      end
    end
    return res;
  endfunction

  // scatter the bits of val onto the set positions of mask, low first
  function automatic int spread(input logic [NumVars-1:0] mask, input int val);
    int res;
    int k;
    res = 0;
    k = 0;
    for (int b = 0; b < NumVars; b++) begin
      if (mask[b]) begin
        if (((val >> k) & 1) != 0) begin
          res = res | (1 << b);
        end
        k++;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/lpdc_if.sv =====
`default_nettype none
interface lpdc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] truth_low;
  logic [63:0] truth_high;
  logic [2:0]  num_leaves;

  modport source (output valid, output truth_low, output truth_high, output num_leaves,
                  input ready);
  modport sink (input valid, input truth_low, input truth_high, input num_leaves,
                output ready);
endinterface

interface lpdc_out_if;
  logic       valid;
  logic       ready;
  logic       decomposable;
  logic [2:0] decomp_kind;

  modport source (output valid, output decomposable, output decomp_kind, input ready);
  modport sink (input valid, input decomposable, input decomp_kind, output ready);
endinterface
`default_nettype wire

// ===== design/lpdc_mux.sv =====
`default_nettype none
module lpdc_mux
  import lpdc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire stage_ld_t            ld_i,
  input  wire logic [TableBits-1:0] tt_i,
  input  wire logic                 seven_i,
  output logic                      mux_ok_o
);

  logic [NumVars-1:0][1:0][NumVars-1:0] dep_d, dep_q;
  logic                                 seven_q;
  logic                                 mux_ok_d, mux_ok_q;

  // dependence of each cofactor on each other variable
  always_comb begin
    logic [TableBits-1:0] f;
    logic [TableBits-1:0] region;
    logic [TableBits-1:0] diff;
    f      = seven_i ? tt_i : {64'b0, tt_i[63:0]};
    region = seven_i ? '1 : {64'b0, {64{1'b1}}};
    dep_d  = '0;
    for (int w = 0; w < NumVars; w++) begin
      diff = (f ^ (f >> (1 << w))) & ~VarMask[w] & region;
      for (int v = 0; v < NumVars; v++) begin
        dep_d[v][0][w] = |(diff & ~VarMask[v]);
        dep_d[v][1][w] = |(diff & VarMask[v]);
      end
    end
  end

  // support size of both cofactors under five
  always_comb begin
    logic [2:0] sz0;
    logic [2:0] sz1;
    logic       in_range;
    mux_ok_d = 1'b0;
    for (int v = 0; v < NumVars; v++) begin
      sz0 = '0;
      sz1 = '0;
      for (int w = 0; w < NumVars; w++) begin
        if (w != v && (w < 6 || seven_q)) begin
          sz0 = sz0 + 3'(dep_q[v][0][w]);
          sz1 = sz1 + 3'(dep_q[v][1][w]);
        end
      end
      in_range = (v < 6) || seven_q;
      if (in_range && sz0 < 3'd5 && sz1 < 3'd5) begin
        mux_ok_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seven_q <= 1'b0;
    end else if (ld_i.ld1) begin
      seven_q <= seven_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      dep_q <= dep_d;
    end
    if (ld_i.ld2) begin
      mux_ok_q <= mux_ok_d;
    end
  end

  assign mux_ok_o = mux_ok_q;

endmodule
`default_nettype wire

// ===== design/lpdc_pair.sv =====
`default_nettype none
module lpdc_pair
  import lpdc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire stage_ld_t   ld_i,
  input  wire logic [63:0] lo_i,
  output logic             disj_o,
  output logic             nd_o
);

  logic [15:0][3:0] pat [NumPairs];

  // cofactor pattern of each row of the free variables
  for (genvar i = 0; i < NumPairs; i++) begin : g_pair
    localparam logic [NumVars-1:0] Sel = pair_sel(i);
    localparam logic [NumVars-1:0] Oth = ~Sel & 7'h3f;
    for (genvar r = 0; r < 16; r++) begin : g_row
      for (genvar p = 0; p < 4; p++) begin : g_bit
        localparam int M = spread(Sel, p) | spread(Oth, r);
        assign pat[i][r][p] = lo_i[M];
      end
    end
  end

  logic [15:0]            pres_d [NumPairs];
  logic [3:0][1:0][15:0]  fix_d  [NumPairs];
  logic [15:0]            pres_q [NumPairs];
  logic [3:0][1:0][15:0]  fix_q  [NumPairs];

  // set of distinct patterns, overall and with one free variable held
  always_comb begin
    logic [15:0] oh;
    for (int i = 0; i < NumPairs; i++) begin
      pres_d[i] = '0;
      fix_d[i]  = '0;
      for (int r = 0; r < 16; r++) begin
        oh = 16'(1) << pat[i][r];
        pres_d[i] = pres_d[i] | oh;
        for (int j = 0; j < 4; j++) begin
          if (((r >> j) & 1) != 0) begin
            fix_d[i][j][1] = fix_d[i][j][1] | oh;
          end else begin
            fix_d[i][j][0] = fix_d[i][j][0] | oh;
          end
        end
      end
    end
  end

  logic disj_d, nd_d, disj_q, nd_q;

  // distinct counts decide disjoint and non-disjoint
  always_comb begin
    int  cnt;
    logic fix_ok;
    disj_d = 1'b0;
    nd_d   = 1'b0;
    for (int i = 0; i < NumPairs; i++) begin
      cnt    = $countones(pres_q[i]);
      fix_ok = 1'b0;
      for (int j = 0; j < 4; j++) begin
        if ($countones(fix_q[i][j][0]) <= 2 && $countones(fix_q[i][j][1]) <= 2) begin
          fix_ok = 1'b1;
        end
      end
      if (cnt <= 2) begin
        disj_d = 1'b1;
      end
      if ((cnt == 3 || cnt == 4) && fix_ok) begin
        nd_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      pres_q <= pres_d;
      fix_q  <= fix_d;
    end
    if (ld_i.ld2) begin
      disj_q <= disj_d;
      nd_q   <= nd_d;
    end
  end

  assign disj_o = disj_q;
  assign nd_o   = nd_q;

endmodule
`default_nettype wire

// ===== design/lpdc_triple.sv =====
`default_nettype none
module lpdc_triple
  import lpdc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire stage_ld_t            ld_i,
  input  wire logic [TableBits-1:0] tt0_i,
  input  wire logic [TableBits-1:0] tt1_i,
  output logic                      disj_o
);

  logic [15:0][7:0] pat0 [NumTriples];
  logic [15:0][7:0] pat1 [NumTriples];

  // 8-bit cofactors taken from both stage copies of the table
  for (genvar i = 0; i < NumTriples; i++) begin : g_tri
    localparam logic [NumVars-1:0] Sel = triple_sel(i);
    localparam logic [NumVars-1:0] Oth = ~Sel;
    for (genvar r = 0; r < 16; r++) begin : g_row
      for (genvar p = 0; p < 8; p++) begin : g_bit
        localparam int M = spread(Sel, p) | spread(Oth, r);
        assign pat0[i][r][p] = tt0_i[M];
        assign pat1[i][r][p] = tt1_i[M];
      end
    end
  end

  logic [15:0] ne_d [NumTriples];
  logic [7:0]  q_d  [NumTriples];
  logic [15:0] ne_q [NumTriples];
  logic [7:0]  q_q  [NumTriples];

  // rows unlike row zero, and the first such row
  always_comb begin
    logic [15:0] seen;
    for (int i = 0; i < NumTriples; i++) begin
      for (int r = 0; r < 16; r++) begin
        ne_d[i][r] = pat0[i][r] != pat0[i][0];
      end
      seen    = '0;
      q_d[i]  = '0;
      for (int r = 1; r < 16; r++) begin
        seen[r] = seen[r-1] | ne_d[i][r-1];
      end
      for (int r = 0; r < 16; r++) begin
        if (ne_d[i][r] && !seen[r]) begin
          q_d[i] = q_d[i] | pat0[i][r];
        end
      end
    end
  end

  logic disj_d, disj_q;

  // at most two distinct cofactors on some triple
  always_comb begin
    logic ok;
    disj_d = 1'b0;
    for (int i = 0; i < NumTriples; i++) begin
      ok = 1'b1;
      for (int r = 0; r < 16; r++) begin
        if (ne_q[i][r] && pat1[i][r] != q_q[i]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        disj_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      ne_q <= ne_d;
      q_q  <= q_d;
    end
    if (ld_i.ld2) begin
      disj_q <= disj_d;
    end
  end

  assign disj_o = disj_q;

endmodule
`default_nettype wire

// ===== design/lut_pair_decomposition_check_unit.sv =====
`default_nettype none
// Checks whether a cut function of up to seven leaves fits two cascaded
// four-input LUTs and reports the kind of fit. Fully pipelined: one
// transaction is accepted every cycle while the output is not stalled, and
// its result passes the input register, two compute stages and the output
// register before it is offered on the output. Each stage holds its item
// until the next one frees, so back-pressure on the output stalls the pipe
// without losing or repeating anything.
module lut_pair_decomposition_check_unit
  import lpdc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpdc_in_if.sink    in_i,
  lpdc_out_if.source out_o
);

  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;
  stage_ld_t ld;

  // per-stage ready chain
  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_i.ready = rdy0;
  assign ld.ld1 = rdy1 && v0_q;
  assign ld.ld2 = rdy2 && v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // payload that travels alongside the compute units
  logic [TableBits-1:0] tt0_q, tt1_q;
  logic [2:0]           lv0_q, lv1_q, lv2_q;

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_i.valid) begin
      tt0_q <= {in_i.truth_high, in_i.truth_low};
      lv0_q <= in_i.num_leaves;
    end
    if (ld.ld1) begin
      tt1_q <= tt0_q;
      lv1_q <= lv0_q;
    end
    if (ld.ld2) begin
      lv2_q <= lv1_q;
    end
  end

  logic mux_ok, pair_disj, pair_nd, tri_disj;

  lpdc_mux u_mux (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (ld),
    .tt_i     (tt0_q),
    .seven_i  (lv0_q == 3'd7),
    .mux_ok_o (mux_ok)
  );

  lpdc_pair u_pair (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .lo_i   (tt0_q[63:0]),
    .disj_o (pair_disj),
    .nd_o   (pair_nd)
  );

  lpdc_triple u_triple (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .tt0_i  (tt0_q),
    .tt1_i  (tt1_q),
    .disj_o (tri_disj)
  );

  // final kind selection
  logic [2:0] kind_d, kind_q;

  always_comb begin
    if (lv2_q < 3'd6) begin
      kind_d = KIND_SMALL;
    end else if (mux_ok) begin
      kind_d = KIND_MUX;
    end else if (lv2_q == 3'd6) begin
      kind_d = pair_disj ? KIND_DISJOINT : (pair_nd ? KIND_NONDISJOINT : KIND_NONE);
    end else begin
      kind_d = tri_disj ? KIND_DISJOINT : KIND_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      kind_q <= kind_d;
    end
  end

  assign out_o.valid        = v3_q;
  assign out_o.decomp_kind  = kind_q;
  assign out_o.decomposable = kind_q != KIND_NONE;

endmodule
`default_nettype wire
